/* src/pid_pkg.sv */
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants of the PID controller
// Fixed-point widths, register indexes, reset values and the request word
// that the sequencer hands to the shared multiplier.
// ----------------------------------------------------------------------------
package pid_pkg;

   // Value format: signed Q(VALUE_WIDTH-FRAC_BITS).FRAC_BITS.
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS = 16;

   // Time step is unsigned Q0.32, its reciprocal unsigned Q24.8.
   localparam int PERIOD_WIDTH = 32;
   localparam int INV_FRAC_BITS = 8;

   // Integral is signed Q32.32. Its halves are also the split used for
   // the integral product, whose fraction equals the half width.
   localparam int INTEG_WIDTH = 64;
   localparam int INTEG_HALF = INTEG_WIDTH / 2;

   // Shared multiplier operand and product widths.
   localparam int MUL_WIDTH = (VALUE_WIDTH > PERIOD_WIDTH) ? VALUE_WIDTH : PERIOD_WIDTH;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;

   // Configuration port.
   localparam int CSR_DATA_WIDTH = MUL_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [PERIOD_WIDTH-1:0] period_type;
   typedef logic signed [INTEG_WIDTH-1:0] integ_type;
   typedef logic [MUL_WIDTH-1:0] mul_op_type;
   typedef logic [PROD_WIDTH-1:0] prod_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0] csr_data_type;

   // Register indexes.
   localparam csr_index_type CSR_PROP_GAIN = CSR_INDEX_WIDTH'(0);
   localparam csr_index_type CSR_INTEG_GAIN = CSR_INDEX_WIDTH'(1);
   localparam csr_index_type CSR_DERIV_GAIN = CSR_INDEX_WIDTH'(2);
   localparam csr_index_type CSR_SETPOINT = CSR_INDEX_WIDTH'(3);
   localparam csr_index_type CSR_TIME_STEP = CSR_INDEX_WIDTH'(4);
   localparam csr_index_type CSR_INV_TIME_STEP = CSR_INDEX_WIDTH'(5);

   // Period reset values: about 0.0001 s and 10000.0.
   localparam period_type TIME_STEP_RESET = PERIOD_WIDTH'(429497);
   localparam period_type INV_TIME_STEP_RESET = PERIOD_WIDTH'(2560000);

   // One multiply request: two magnitudes and the sign of their product.
   typedef struct packed {
      mul_op_type op_a;
      mul_op_type op_b;
      logic       neg;
   } mul_req_type;

endpackage

/* src/pid_mul.sv */
// ----------------------------------------------------------------------------
// pid_mul: shared unsigned multiplier
// Multiplies two operand magnitudes and registers the product together with
// the sign that the sequencer attached to the request.
// ----------------------------------------------------------------------------
module pid_mul (
   input  logic                 clock,
   input  pid_pkg::mul_req_type mul_req,
   output pid_pkg::prod_type    mul_prod,
   output logic                 mul_neg
);
   import pid_pkg::*;

   prod_type prod_ff;
   logic     neg_ff;

   // One product per cycle, registered before any use.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_WIDTH'(mul_req.op_a) * PROD_WIDTH'(mul_req.op_b);
      neg_ff <= mul_req.neg;
   end

   assign mul_prod = prod_ff;
   assign mul_neg = neg_ff;

endmodule

/* src/pid_controller.sv */
// ----------------------------------------------------------------------------
// pid_controller: fixed-point PID controller
// Takes one measured position per control tick and returns the saturated
// drive together with the error, integral and derivative of that tick.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             word
//   req_      in          req_valid/req_ready   measured position
//   rsp_      out         rsp_valid/rsp_ready   drive, error, integral, derivative, flag
//   csr_      in          csr_valid/csr_ready   register index and data
//
// Between one acceptance and the next, the error is formed at acceptance,
// then six products pass one by one through the single shared multiplier,
// and a final step clips the drive into the result word.
// The result register frees the sequencer unless an earlier word is still
// waiting, in which case the final step holds until rsp_ready.
// Reset is synchronous and restores registers, previous error and integral.
// The configuration port is always ready.
//
module pid_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pid_pkg::value_type     req_measured_position,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pid_pkg::value_type     rsp_drive,
   output pid_pkg::value_type     rsp_error_now,
   output pid_pkg::integ_type     rsp_integral_now,
   output pid_pkg::value_type     rsp_derivative_now,
   output logic                   rsp_saturated,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  pid_pkg::csr_index_type csr_index,
   input  pid_pkg::csr_data_type  csr_data
);
   import pid_pkg::*;

   localparam int PART_WIDTH = PROD_WIDTH + 1 - INTEG_HALF;

   typedef logic [PROD_WIDTH:0] wide_type;
   typedef logic [VALUE_WIDTH-1:0] mag_type;
   typedef logic signed [VALUE_WIDTH:0] diff_type;

   localparam wide_type RND_FRAC = wide_type'(1) << (FRAC_BITS - 1);
   localparam wide_type RND_INV = wide_type'(1) << (INV_FRAC_BITS - 1);
   localparam wide_type RND_HALF = wide_type'(1) << (INTEG_HALF - 1);

   localparam integ_type INTEG_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
   localparam integ_type INTEG_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Sequencer codes; each step from S_M2 to S_M7 retires the previous product.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_M1 = 4'd1;
   localparam logic [3:0] S_M2 = 4'd2;
   localparam logic [3:0] S_M3 = 4'd3;
   localparam logic [3:0] S_M4 = 4'd4;
   localparam logic [3:0] S_M5 = 4'd5;
   localparam logic [3:0] S_M6 = 4'd6;
   localparam logic [3:0] S_M7 = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   // Magnitude of a signed value.
   function automatic mag_type mag_value(input value_type x);
      mag_type u;
      u = x;
      return u[VALUE_WIDTH-1] ? (~u + 1'b1) : u;
   endfunction

   // True when a 64-bit value does not fit the value width.
   function automatic logic value_ovf(input integ_type x);
      return !((&x[INTEG_WIDTH-1:VALUE_WIDTH-1]) || !(|x[INTEG_WIDTH-1:VALUE_WIDTH-1]));
   endfunction

   // Clip a 64-bit value to the value width.
   function automatic value_type clip_value(input integ_type x);
      if (value_ovf(x)) begin
         return x[INTEG_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
      end
      return x[VALUE_WIDTH-1:0];
   endfunction

   // Registers.
   logic [3:0]    state_ff, state_in;
   value_type     prop_gain_ff, integ_gain_ff, deriv_gain_ff, setpoint_ff;
   period_type    time_step_ff, inv_time_step_ff;
   value_type     err_ff, err_in;
   value_type     prev_ff, prev_in;
   diff_type      dlt_ff, dlt_in;
   integ_type     integ_ff, integ_in;
   value_type     deriv_ff, deriv_in;
   integ_type     p_ff, p_in;
   logic [PART_WIDTH-1:0] part_ff, part_in;
   integ_type     acc_ff, acc_in;
   logic          sat_ff, sat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   value_type     rsp_drive_ff, rsp_drive_in;
   value_type     rsp_error_ff, rsp_error_in;
   integ_type     rsp_integ_ff, rsp_integ_in;
   value_type     rsp_deriv_ff, rsp_deriv_in;
   logic          rsp_sat_ff, rsp_sat_in;

   // Datapath signals.
   mul_req_type   mul_req;
   prod_type      mul_prod;
   logic          mul_neg;
   wide_type      prod_ext, rnd_frac, rnd_inv, rnd_half, shift_mag;
   logic          term_ovf;
   integ_type     term;
   integ_type     add_a, add_res;
   logic [INTEG_WIDTH:0] add_sum;
   logic          add_ovf;
   diff_type      err_diff;
   logic          err_ovf;
   value_type     err_clip;
   logic [VALUE_WIDTH:0] dlt_mag;
   logic [INTEG_WIDTH-1:0] integ_u, integ_mag;
   logic          accept, rsp_load;

   pid_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .mul_prod(mul_prod),
      .mul_neg (mul_neg)
   );

   assign accept = req_valid && req_ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Error at acceptance, clipped to the value width.
   always_comb begin
      err_diff = {setpoint_ff[VALUE_WIDTH-1], setpoint_ff}
               - {req_measured_position[VALUE_WIDTH-1], req_measured_position};
      err_ovf = err_diff[VALUE_WIDTH] != err_diff[VALUE_WIDTH-1];
      if (err_ovf) begin
         err_clip = err_diff[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
      end else begin
         err_clip = err_diff[VALUE_WIDTH-1:0];
      end
   end

   // Operand magnitudes for the error change and the integral.
   always_comb begin
      dlt_mag = dlt_ff[VALUE_WIDTH] ? (~dlt_ff + 1'b1) : dlt_ff;
      integ_u = integ_ff;
      integ_mag = integ_u[INTEG_WIDTH-1] ? (~integ_u + 1'b1) : integ_u;
   end

   // Multiply request for each step.
   always_comb begin
      mul_req = '0;
      case (state_ff)
         S_M1: begin
            mul_req.op_a = MUL_WIDTH'(mag_value(err_ff));
            mul_req.op_b = MUL_WIDTH'(time_step_ff);
            mul_req.neg = err_ff[VALUE_WIDTH-1];
         end
         S_M2: begin
            mul_req.op_a = MUL_WIDTH'(dlt_mag[VALUE_WIDTH-1:0]);
            mul_req.op_b = MUL_WIDTH'(inv_time_step_ff);
            mul_req.neg = dlt_ff[VALUE_WIDTH];
         end
         S_M3: begin
            mul_req.op_a = MUL_WIDTH'(mag_value(prop_gain_ff));
            mul_req.op_b = MUL_WIDTH'(mag_value(err_ff));
            mul_req.neg = prop_gain_ff[VALUE_WIDTH-1] ^ err_ff[VALUE_WIDTH-1];
         end
         S_M4: begin
            mul_req.op_a = MUL_WIDTH'(mag_value(integ_gain_ff));
            mul_req.op_b = MUL_WIDTH'(integ_mag[INTEG_HALF-1:0]);
            mul_req.neg = integ_gain_ff[VALUE_WIDTH-1] ^ integ_ff[INTEG_WIDTH-1];
         end
         S_M5: begin
            mul_req.op_a = MUL_WIDTH'(mag_value(integ_gain_ff));
            mul_req.op_b = MUL_WIDTH'(integ_mag[INTEG_WIDTH-1:INTEG_HALF]);
            mul_req.neg = integ_gain_ff[VALUE_WIDTH-1] ^ integ_ff[INTEG_WIDTH-1];
         end
         S_M6: begin
            mul_req.op_a = MUL_WIDTH'(mag_value(deriv_gain_ff));
            mul_req.op_b = MUL_WIDTH'(mag_value(deriv_ff));
            mul_req.neg = deriv_gain_ff[VALUE_WIDTH-1] ^ deriv_ff[VALUE_WIDTH-1];
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   // Round the previous product half away from zero and scale it; S_M6 adds part_ff.
   always_comb begin
      prod_ext = {1'b0, mul_prod};
      rnd_frac = (prod_ext + RND_FRAC) >> FRAC_BITS;
      rnd_inv = (prod_ext + RND_INV) >> INV_FRAC_BITS;
      rnd_half = (prod_ext + RND_HALF) >> INTEG_HALF;
      case (state_ff)
         S_M3:    shift_mag = rnd_inv;
         S_M5:    shift_mag = rnd_half;
         S_M6:    shift_mag = prod_ext + wide_type'(part_ff);
         default: shift_mag = rnd_frac;
      endcase
   end

   // Apply the sign and saturate the term to 64 bits.
   always_comb begin
      if (mul_neg) begin
         term_ovf = (|shift_mag[PROD_WIDTH:INTEG_WIDTH])
                 || (shift_mag[INTEG_WIDTH-1] && (|shift_mag[INTEG_WIDTH-2:0]));
      end else begin
         term_ovf = |shift_mag[PROD_WIDTH:INTEG_WIDTH-1];
      end
      if (term_ovf) begin
         term = mul_neg ? INTEG_MIN : INTEG_MAX;
      end else if (mul_neg) begin
         term = INTEG_WIDTH'(0) - shift_mag[INTEG_WIDTH-1:0];
      end else begin
         term = shift_mag[INTEG_WIDTH-1:0];
      end
   end

   // Shared saturating 64-bit adder.
   always_comb begin
      case (state_ff)
         S_M6:    add_a = p_ff;
         S_M7:    add_a = acc_ff;
         default: add_a = integ_ff;
      endcase
      add_sum = {add_a[INTEG_WIDTH-1], add_a} + {term[INTEG_WIDTH-1], term};
      add_ovf = add_sum[INTEG_WIDTH] != add_sum[INTEG_WIDTH-1];
      if (add_ovf) begin
         add_res = add_sum[INTEG_WIDTH] ? INTEG_MIN : INTEG_MAX;
      end else begin
         add_res = add_sum[INTEG_WIDTH-1:0];
      end
   end

   // Sequencer and working registers.
   always_comb begin
      state_in = state_ff;
      err_in = err_ff;
      prev_in = prev_ff;
      dlt_in = dlt_ff;
      integ_in = integ_ff;
      deriv_in = deriv_ff;
      p_in = p_ff;
      part_in = part_ff;
      acc_in = acc_ff;
      sat_in = sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               err_in = err_clip;
               sat_in = err_ovf;
               state_in = S_M1;
            end
         end
         S_M1: begin
            dlt_in = {err_ff[VALUE_WIDTH-1], err_ff} - {prev_ff[VALUE_WIDTH-1], prev_ff};
            prev_in = err_ff;
            state_in = S_M2;
         end
         S_M2: begin
            integ_in = add_res;
            sat_in = sat_ff | term_ovf | add_ovf;
            state_in = S_M3;
         end
         S_M3: begin
            deriv_in = clip_value(term);
            sat_in = sat_ff | term_ovf | value_ovf(term);
            state_in = S_M4;
         end
         S_M4: begin
            p_in = term;
            sat_in = sat_ff | term_ovf;
            state_in = S_M5;
         end
         S_M5: begin
            part_in = shift_mag[PART_WIDTH-1:0];
            state_in = S_M6;
         end
         S_M6: begin
            acc_in = add_res;
            sat_in = sat_ff | term_ovf | add_ovf;
            state_in = S_M7;
         end
         S_M7: begin
            acc_in = add_res;
            sat_in = sat_ff | term_ovf | add_ovf;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result word.
   always_comb begin
      rsp_drive_in = rsp_drive_ff;
      rsp_error_in = rsp_error_ff;
      rsp_integ_in = rsp_integ_ff;
      rsp_deriv_in = rsp_deriv_ff;
      rsp_sat_in = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_drive_in = clip_value(acc_ff);
         rsp_error_in = err_ff;
         rsp_integ_in = integ_ff;
         rsp_deriv_in = deriv_ff;
         rsp_sat_in = sat_ff | value_ovf(acc_ff);
         rsp_valid_in = 1'b1;
      end
   end

   // Control state and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff <= '0;
         integ_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff <= prev_in;
         integ_ff <= integ_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         setpoint_ff <= '0;
         time_step_ff <= TIME_STEP_RESET;
         inv_time_step_ff <= INV_TIME_STEP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PROP_GAIN:     prop_gain_ff <= csr_data[VALUE_WIDTH-1:0];
            CSR_INTEG_GAIN:    integ_gain_ff <= csr_data[VALUE_WIDTH-1:0];
            CSR_DERIV_GAIN:    deriv_gain_ff <= csr_data[VALUE_WIDTH-1:0];
            CSR_SETPOINT:      setpoint_ff <= csr_data[VALUE_WIDTH-1:0];
            CSR_TIME_STEP:     time_step_ff <= csr_data[PERIOD_WIDTH-1:0];
            CSR_INV_TIME_STEP: inv_time_step_ff <= csr_data[PERIOD_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      err_ff <= err_in;
      dlt_ff <= dlt_in;
      deriv_ff <= deriv_in;
      p_ff <= p_in;
      part_ff <= part_in;
      acc_ff <= acc_in;
      sat_ff <= sat_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_error_ff <= rsp_error_in;
      rsp_integ_ff <= rsp_integ_in;
      rsp_deriv_ff <= rsp_deriv_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;
   assign rsp_error_now = rsp_error_ff;
   assign rsp_integral_now = rsp_integ_ff;
   assign rsp_derivative_now = rsp_deriv_ff;
   assign rsp_saturated = rsp_sat_ff;

   // An accepted word always starts the multiply sequence.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_M1))
      else $error("accepted word did not start the sequence");

   // The sequencer never takes a word while it works on one.
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("ready raised while busy");

   // The previous error is updated before the derivative product is issued.
   a_prev_updated: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_M2) |-> (prev_ff == err_ff))
      else $error("previous error not updated");

   // A new result word only comes from the final step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result word appeared outside the final step");

endmodule

/* sim/pid_controller_test.sv */
// ----------------------------------------------------------------------------
// pid_controller_test: self-checking bench for the fixed-point PID controller
// Walks a short table of register writes and control ticks, then runs random
// phases of register settings followed by position trajectories. Every result
// word is checked field by field against a bit-exact PID predictor or table.
// ----------------------------------------------------------------------------
module pid_controller_test;
   import pid_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TICK_TOTAL = 1450;
   localparam int CALM_FROM = 1250;
   localparam int DRAIN_CYCLES = 30;

   // Register slots past the last real one; writes there must be ignored.
   localparam csr_index_type CSR_SPARE_LOW = csr_index_type'(6);
   localparam csr_index_type CSR_SPARE_HIGH = csr_index_type'(7);

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [63:0] CLIP_HI = VALUE_MAX;
   localparam logic signed [63:0] CLIP_LO = VALUE_MIN;
   localparam logic signed [63:0] WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] WIDE_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      value_type  drive;
      value_type  error_now;
      integ_type  integral_now;
      value_type  derivative_now;
      logic       saturated;
   } tick_result_type;

   typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      csr_index_type   index;
      csr_data_type    data;
      value_type       position;
      bit              typed;
      tick_result_type result;
   } plan_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   value_type     req_measured_position;
   logic          rsp_valid;
   logic          rsp_ready;
   value_type     rsp_drive;
   value_type     rsp_error_now;
   integ_type     rsp_integral_now;
   value_type     rsp_derivative_now;
   logic          rsp_saturated;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   csr_data_type  csr_data;

   // Predictor copy of the registers and of the controller state.
   logic signed [63:0] gain_p = '0;
   logic signed [63:0] gain_i = '0;
   logic signed [63:0] gain_d = '0;
   logic signed [63:0] target = '0;
   logic signed [63:0] period = {32'd0, TIME_STEP_RESET};
   logic signed [63:0] rate = {32'd0, INV_TIME_STEP_RESET};
   logic signed [63:0] last_error = '0;
   logic signed [63:0] integral_acc = '0;
   bit                 tick_clipped;

   tick_result_type outstanding_ticks[$];
   plan_row_type    plan[$];
   value_type       track = '0;
   bit              bursty = 1'b1;
   int              items_sent = 0;
   int              failures = 0;
   int              cycle_count = 0;

   pid_controller DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_measured_position(req_measured_position),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive(rsp_drive),
      .rsp_error_now(rsp_error_now),
      .rsp_integral_now(rsp_integral_now),
      .rsp_derivative_now(rsp_derivative_now),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Clip a wide value into the value width and note the clip.
   function automatic logic signed [63:0] clip_value(input logic signed [63:0] v);
      if (v > CLIP_HI) begin
         tick_clipped = 1'b1;
         return CLIP_HI;
      end
      if (v < CLIP_LO) begin
         tick_clipped = 1'b1;
         return CLIP_LO;
      end
      return v;
   endfunction

   // Exact product shifted right by sh, rounded half away from zero,
   // saturated to 64 bits.
   function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] mag;
      logic [127:0] q;
      bit           neg;
      neg = a[63] ^ b[63];
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = b[63] ? 64'(-b) : 64'(b);
      mag = {64'd0, ma} * {64'd0, mb};
      q = (mag + (128'd1 << (sh - 1))) >> sh;
      if (!neg) begin
         if (q > 128'h7FFF_FFFF_FFFF_FFFF) begin
            tick_clipped = 1'b1;
            return WIDE_MAX;
         end
         return $signed(q[63:0]);
      end
      if (q > 128'h8000_0000_0000_0000) begin
         tick_clipped = 1'b1;
         return WIDE_MIN;
      end
      return -$signed(q[63:0]);
   endfunction

   // 64-bit add that saturates on overflow.
   function automatic logic signed [63:0] sum_clamped(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         tick_clipped = 1'b1;
         return s[64] ? WIDE_MIN : WIDE_MAX;
      end
      return $signed(s[63:0]);
   endfunction

   // One control tick: error, integral, derivative and the clipped drive.
   function automatic tick_result_type control_step(input value_type m);
      logic signed [63:0] m64;
      logic signed [63:0] err;
      logic signed [63:0] deriv;
      logic signed [63:0] p;
      logic signed [63:0] i;
      logic signed [63:0] d;
      tick_result_type    r;
      tick_clipped = 1'b0;
      m64 = m;
      err = clip_value(target - m64);
      integral_acc = sum_clamped(integral_acc, scaled_product(err, period, FRAC_BITS));
      deriv = clip_value(scaled_product(err - last_error, rate, INV_FRAC_BITS));
      last_error = err;
      p = scaled_product(gain_p, err, FRAC_BITS);
      i = scaled_product(gain_i, integral_acc, INTEG_HALF);
      d = scaled_product(gain_d, deriv, FRAC_BITS);
      r.drive = clip_value(sum_clamped(sum_clamped(p, i), d));
      r.error_now = err[VALUE_WIDTH-1:0];
      r.integral_now = integral_acc;
      r.derivative_now = deriv[VALUE_WIDTH-1:0];
      r.saturated = tick_clipped;
      return r;
   endfunction

   function automatic plan_row_type reg_row(input csr_index_type idx, input csr_data_type data);
      plan_row_type row;
      row = '{kind: ROW_WRITE, index: idx, data: data, position: '0, typed: 1'b0,
              result: '0};
      return row;
   endfunction

   function automatic plan_row_type tick_row(input value_type m, input bit typed,
                                             input tick_result_type r);
      plan_row_type row;
      row = '{kind: ROW_TICK, index: CSR_PROP_GAIN, data: '0, position: m, typed: typed,
              result: r};
      return row;
   endfunction

   // Append one row at the end of the stimulus table.
   function automatic void queue_row(input plan_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   function automatic value_type extreme_value();
      case ($urandom_range(0, 4))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         3: return value_type'(1);
         default: return '1;
      endcase
   endfunction

   // Gains and setpoints: mostly modest values, some full range, some extremes.
   function automatic csr_data_type pick_word();
      case ($urandom_range(0, 9))
         0, 1: return extreme_value();
         2, 3, 4: return $urandom;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   // Position trajectory: mostly a noisy approach to the setpoint, with jumps.
   function automatic value_type next_position();
      logic signed [63:0] p64;
      int                 noise;
      case ($urandom_range(0, 9))
         7, 8: track = $urandom;
         9: track = extreme_value();
         default: begin
            noise = int'($urandom_range(0, 131072)) - 65536;
            p64 = track;
            p64 = p64 + (target - p64) / 4 + noise;
            if (p64 > CLIP_HI) p64 = CLIP_HI;
            else if (p64 < CLIP_LO) p64 = CLIP_LO;
            track = p64[VALUE_WIDTH-1:0];
         end
      endcase
      return track;
   endfunction

   // Register write, only once every outstanding word has come back.
   task automatic write_register(input csr_index_type idx, input csr_data_type data);
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding_ticks.size() != 0) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PROP_GAIN: gain_p = $signed(data);
         CSR_INTEG_GAIN: gain_i = $signed(data);
         CSR_DERIV_GAIN: gain_d = $signed(data);
         CSR_SETPOINT: target = $signed(data);
         CSR_TIME_STEP: period = {32'd0, data};
         CSR_INV_TIME_STEP: rate = {32'd0, data};
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offer one measurement word, then record what the controller must return.
   task automatic send_item(input value_type m, input bit typed, input tick_result_type fixed);
      int              gap;
      tick_result_type predicted;
      gap = (bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_measured_position = m;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = control_step(m);
      outstanding_ticks.insert(outstanding_ticks.size(), typed ? fixed : predicted);
      items_sent++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         failures++;
      end
   endtask

   // Result side: stalls come in short bursts while the phase is bursty.
   initial begin : result_stalls
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready = 1'b0;
            hold--;
         end else if (bursty && $urandom_range(0, 3) == 0) begin
            hold = $urandom_range(0, 4);
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Each accepted result word is matched against the oldest expectation.
   always @(posedge clock) begin : check_results
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outstanding_ticks.size() == 0) begin
            $display("%0t: unexpected result word, drive %h", $time, rsp_drive);
            failures++;
         end else begin
            want = outstanding_ticks.pop_front();
            compare_field("drive", want.drive, rsp_drive);
            compare_field("error_now", want.error_now, rsp_error_now);
            compare_field("integral_now", want.integral_now, rsp_integral_now);
            compare_field("derivative_now", want.derivative_now, rsp_derivative_now);
            compare_field("saturated", want.saturated, rsp_saturated);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pid_controller_test NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      tick_result_type err_high;
      tick_result_type err_low;
      csr_data_type    ts;
      csr_data_type    its;
      logic [63:0]     recip;
      int              count;
      bit              first_phase;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_measured_position = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PROP_GAIN;
      csr_data = '0;

      // With zero gains and zero periods only the clipped error and the saturation flag are nonzero.
      err_high = '{drive: '0, error_now: VALUE_MAX, integral_now: '0, derivative_now: '0,
                   saturated: 1'b1};
      err_low = '{drive: '0, error_now: VALUE_MIN, integral_now: '0, derivative_now: '0,
                  saturated: 1'b1};

      queue_row(tick_row('0, 1'b1, '0));
      queue_row(reg_row(CSR_TIME_STEP, '0));
      queue_row(reg_row(CSR_INV_TIME_STEP, '0));
      queue_row(reg_row(CSR_SETPOINT, VALUE_MAX));
      queue_row(tick_row(VALUE_MIN, 1'b1, err_high));
      queue_row(reg_row(CSR_SETPOINT, VALUE_MIN));
      queue_row(tick_row(VALUE_MAX, 1'b1, err_low));
      // Back to the reset periods, extremes of the measurement.
      queue_row(reg_row(CSR_SETPOINT, '0));
      queue_row(reg_row(CSR_TIME_STEP, TIME_STEP_RESET));
      queue_row(reg_row(CSR_INV_TIME_STEP, INV_TIME_STEP_RESET));
      queue_row(tick_row(VALUE_MAX, 1'b0, '0));
      queue_row(tick_row(VALUE_MIN, 1'b0, '0));
      queue_row(tick_row(32'h0001_0000, 1'b0, '0));
      queue_row(tick_row('1, 1'b0, '0));
      // Ordinary gains approaching a setpoint of 5.0.
      queue_row(reg_row(CSR_PROP_GAIN, 32'h0001_0000));
      queue_row(reg_row(CSR_INTEG_GAIN, 32'h0000_8000));
      queue_row(reg_row(CSR_DERIV_GAIN, 32'h0000_0100));
      queue_row(reg_row(CSR_SETPOINT, 32'h0005_0000));
      queue_row(tick_row('0, 1'b0, '0));
      queue_row(tick_row(32'h0001_0000, 1'b0, '0));
      queue_row(tick_row(32'h0002_8000, 1'b0, '0));
      queue_row(tick_row(32'h0005_0000, 1'b0, '0));
      queue_row(tick_row(32'h0006_0000, 1'b0, '0));
      // Extreme gains and the longest time step drive the output into clipping.
      queue_row(reg_row(CSR_PROP_GAIN, VALUE_MAX));
      queue_row(reg_row(CSR_INTEG_GAIN, VALUE_MIN));
      queue_row(reg_row(CSR_DERIV_GAIN, VALUE_MAX));
      queue_row(reg_row(CSR_TIME_STEP, '1));
      queue_row(reg_row(CSR_INV_TIME_STEP, 32'h0000_0100));
      queue_row(tick_row(VALUE_MIN, 1'b0, '0));
      queue_row(tick_row(VALUE_MAX, 1'b0, '0));
      queue_row(tick_row('0, 1'b0, '0));
      queue_row(tick_row(value_type'(1), 1'b0, '0));
      // Writes past the last register leave everything as it was.
      queue_row(reg_row(CSR_SPARE_LOW, '1));
      queue_row(reg_row(CSR_SPARE_HIGH, 32'h1234_5678));
      queue_row(tick_row(32'h0000_1234, 1'b0, '0));
      queue_row(tick_row(32'hFFFF_EDCC, 1'b0, '0));
      queue_row(reg_row(CSR_PROP_GAIN, VALUE_MIN));
      queue_row(reg_row(CSR_INTEG_GAIN, VALUE_MAX));
      queue_row(reg_row(CSR_DERIV_GAIN, VALUE_MIN));
      queue_row(reg_row(CSR_INV_TIME_STEP, '1));
      queue_row(tick_row(VALUE_MAX, 1'b0, '0));
      queue_row(tick_row(VALUE_MIN, 1'b0, '0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_WRITE) write_register(plan[k].index, plan[k].data);
         else send_item(plan[k].position, plan[k].typed, plan[k].result);
      end

      // Random phases: a fresh register setting, then a position trajectory.
      first_phase = 1'b1;
      while (items_sent < TICK_TOTAL) begin
         bursty = (items_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
         if (first_phase || $urandom_range(0, 1)) write_register(CSR_PROP_GAIN, pick_word());
         if (first_phase || $urandom_range(0, 1)) write_register(CSR_INTEG_GAIN, pick_word());
         if (first_phase || $urandom_range(0, 1)) write_register(CSR_DERIV_GAIN, pick_word());
         if (first_phase || $urandom_range(0, 1)) write_register(CSR_SETPOINT, pick_word());
         if (first_phase || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0: ts = '0;
               1: ts = '1;
               2: ts = $urandom;
               default: ts = $urandom_range(1, 32'h0100_0000);
            endcase
            // The reciprocal sometimes matches the step, sometimes it does not.
            case ($urandom_range(0, 4))
               0: its = '0;
               1: its = '1;
               2: its = $urandom;
               default: begin
                  if (ts == '0) begin
                     its = $urandom;
                  end else begin
                     recip = (64'd1 << 40) / {32'd0, ts};
                     its = (recip > 64'hFFFF_FFFF) ? '1 : recip[31:0];
                  end
               end
            endcase
            write_register(CSR_TIME_STEP, ts);
            write_register(CSR_INV_TIME_STEP, its);
         end
         if ($urandom_range(0, 7) == 0) begin
            write_register($urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH, $urandom);
         end
         first_phase = 1'b0;
         count = $urandom_range(20, 120);
         if (count > TICK_TOTAL - items_sent) count = TICK_TOTAL - items_sent;
         repeat (count) send_item(next_position(), 1'b0, '0);
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding_ticks.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("pid_controller_test OK");
      end else begin
         $display("pid_controller_test NOT OK");
      end
      $finish;
   end

endmodule
